FILE: rtl/core/awar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awar_pkg
// Shared types and constants of the area-weighted audio resampler.
// ----------------------------------------------------------------------------
package awar_pkg;

    localparam int DEF_FRACTION_BITS = 9;
    localparam int SAMPLE_W          = 16;
    localparam int RATIO_W           = 15;
    localparam int CNT_W             = 6;
    localparam int MAX_UNITS         = 63;
    localparam int Q_DEPTH           = 2;

    typedef enum logic [1:0] {
        MODE_DOWN,
        MODE_UNITY,
        MODE_UP
    } mode_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL1,
        FS_MUL2,
        FS_UPD
    } front_state_t;

    typedef struct packed {
        logic                       first_vld;
        logic signed [SAMPLE_W-1:0] first_val;
        logic signed [SAMPLE_W-1:0] rpt_val;
        logic [CNT_W-1:0]           rpt_cnt;
        logic                       last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: rtl/core/awar_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awar_if
// Valid/ready channels of the resampler: input, output and ratio write.
// ----------------------------------------------------------------------------
interface awar_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [awar_pkg::SAMPLE_W-1:0] in_sample;
    logic                                 is_last;

    modport source (output valid, output in_sample, output is_last, input ready);
    modport sink (input valid, input in_sample, input is_last, output ready);
endinterface

interface awar_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [awar_pkg::SAMPLE_W-1:0] out_sample;
    logic                                 out_last;

    modport source (output valid, output out_sample, output out_last, input ready);
    modport sink (input valid, input out_sample, input out_last, output ready);
endinterface

interface awar_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [awar_pkg::RATIO_W-1:0]  step_ratio;

    modport source (output valid, output step_ratio, input ready);
    modport sink (input valid, input step_ratio, output ready);
endinterface

FILE: rtl/core/awar_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awar_front
// Accepts samples, runs the area weighting through one shared multiplier,
// updates the run state and queues a descriptor when a sample yields words.
// ----------------------------------------------------------------------------
module awar_front #(
    parameter int FRACTION_BITS = awar_pkg::DEF_FRACTION_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    awar_in_if.sink          src,
    awar_cfg_if.sink         cfg,
    output logic             push,
    output awar_pkg::entry_t push_data,
    input  awar_pkg::q_stat_t q_stat
);

    localparam int FB    = FRACTION_BITS;
    localparam int W_W   = FB + 1;
    localparam int ACC_W = awar_pkg::SAMPLE_W + FB;
    localparam int EFF_W = (FB + 6 > awar_pkg::RATIO_W) ? FB + 6 : awar_pkg::RATIO_W;
    localparam int SW    = awar_pkg::SAMPLE_W;
    localparam int CW    = awar_pkg::CNT_W;

    localparam logic [EFF_W-1:0] UNITY     = {{(EFF_W-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
    localparam logic [EFF_W-1:0] MAX_RATIO = EFF_W'(awar_pkg::MAX_UNITS) << FB;
    localparam logic [W_W-1:0]   UNITY_W   = {1'b1, {FB{1'b0}}};

    awar_pkg::front_state_t state_reg, state_next;
    awar_pkg::mode_t        mode_reg;
    awar_pkg::mode_t        cfg_mode;

    logic [EFF_W-1:0]        ratio_reg;
    logic [W_W-1:0]          rem_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SW-1:0]    held_reg;
    logic signed [SW-1:0]    smp_reg;
    logic                    last_reg;
    logic signed [ACC_W-1:0] p1_reg;
    logic signed [ACC_W-1:0] p2_reg;

    logic [EFF_W-1:0]        cfg_eff;
    logic [EFF_W-1:0]        frac;
    logic [EFF_W-1:0]        tot;
    logic [W_W-1:0]          r_w;
    logic [W_W-1:0]          take;
    logic                    fill;
    logic signed [SW-1:0]    mul_a;
    logic [W_W-1:0]          mul_w;
    logic signed [SW+W_W:0]  prod_full;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] blend;

    logic                    need;
    logic                    upd_done;
    awar_pkg::entry_t        ent;
    logic [W_W-1:0]          rem_n;
    logic signed [ACC_W-1:0] acc_n;
    logic signed [SW-1:0]    held_n;

    // ratio register decode
    always_comb
    begin
        cfg_eff = (EFF_W'(cfg.step_ratio) > MAX_RATIO) ? MAX_RATIO : EFF_W'(cfg.step_ratio);
        if (cfg_eff < UNITY)
        begin
            cfg_mode = awar_pkg::MODE_DOWN;
        end
        else if (cfg_eff == UNITY)
        begin
            cfg_mode = awar_pkg::MODE_UNITY;
        end
        else
        begin
            cfg_mode = awar_pkg::MODE_UP;
        end
    end

    assign cfg.ready = 1'b1;

    assign r_w  = ratio_reg[W_W-1:0];
    assign fill = EFF_W'(rem_reg) <= ratio_reg;
    assign frac = ratio_reg - EFF_W'(rem_reg);
    assign take = UNITY_W - rem_reg;
    assign tot  = ratio_reg - EFF_W'(take);

    // shared multiplier operands
    always_comb
    begin
        mul_a = smp_reg;
        mul_w = take;
        if (state_reg == awar_pkg::FS_MUL1)
        begin
            if (mode_reg == awar_pkg::MODE_DOWN)
            begin
                mul_w = fill ? rem_reg : r_w;
            end
            else
            begin
                mul_a = held_reg;
                mul_w = rem_reg;
            end
        end
        else if (mode_reg == awar_pkg::MODE_DOWN)
        begin
            mul_w = frac[W_W-1:0];
        end
    end

    assign prod_full = mul_a * $signed({1'b0, mul_w});
    assign prod      = prod_full[ACC_W-1:0];
    assign sum       = acc_reg + p1_reg;
    assign blend     = p1_reg + p2_reg;

    // state update and result descriptor
    always_comb
    begin
        ent           = '0;
        ent.last      = last_reg;
        rem_n         = rem_reg;
        acc_n         = acc_reg;
        held_n        = held_reg;
        need          = 1'b1;
        unique case (mode_reg)
            awar_pkg::MODE_DOWN:
            begin
                if (fill)
                begin
                    rem_n = UNITY_W - frac[W_W-1:0];
                    acc_n = p2_reg;
                end
                else
                begin
                    rem_n = rem_reg - r_w;
                    acc_n = sum;
                end
                ent.first_vld = fill;
                ent.first_val = sum[FB +: SW];
                ent.rpt_val   = acc_n[FB +: SW];
                ent.rpt_cnt   = CW'(last_reg && (rem_n != UNITY_W));
                need          = fill || (last_reg && (rem_n != UNITY_W));
            end
            awar_pkg::MODE_UP:
            begin
                rem_n         = {1'b0, tot[FB-1:0]};
                held_n        = smp_reg;
                ent.first_vld = 1'b1;
                ent.first_val = blend[FB +: SW];
                ent.rpt_val   = smp_reg;
                ent.rpt_cnt   = tot[FB +: CW] + CW'(last_reg && (rem_n != '0));
            end
            default:
            begin
                ent.first_vld = 1'b1;
                ent.first_val = smp_reg;
                ent.rpt_val   = smp_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            awar_pkg::FS_IDLE:
            begin
                if (src.valid)
                begin
                    state_next = awar_pkg::FS_MUL1;
                end
            end
            awar_pkg::FS_MUL1: state_next = awar_pkg::FS_MUL2;
            awar_pkg::FS_MUL2: state_next = awar_pkg::FS_UPD;
            awar_pkg::FS_UPD:
            begin
                if (upd_done)
                begin
                    state_next = awar_pkg::FS_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        src.ready = 1'b0;
        push      = 1'b0;
        upd_done  = 1'b0;
        unique case (state_reg)
            awar_pkg::FS_IDLE: src.ready = 1'b1;
            awar_pkg::FS_UPD:
            begin
                push     = need && !q_stat.full;
                upd_done = !need || !q_stat.full;
            end
            default:
            begin
            end
        endcase
    end

    assign push_data = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= awar_pkg::FS_IDLE;
            ratio_reg <= UNITY;
            mode_reg  <= awar_pkg::MODE_UNITY;
            rem_reg   <= '0;
            acc_reg   <= '0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                ratio_reg <= cfg_eff;
                mode_reg  <= cfg_mode;
                rem_reg   <= (cfg_mode == awar_pkg::MODE_DOWN) ? UNITY_W : '0;
                acc_reg   <= '0;
                held_reg  <= '0;
            end
            else if (upd_done)
            begin
                if (last_reg)
                begin
                    rem_reg  <= (mode_reg == awar_pkg::MODE_DOWN) ? UNITY_W : '0;
                    acc_reg  <= '0;
                    held_reg <= '0;
                end
                else
                begin
                    rem_reg  <= rem_n;
                    acc_reg  <= acc_n;
                    held_reg <= held_n;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            smp_reg  <= src.in_sample;
            last_reg <= src.is_last;
        end
        if (state_reg == awar_pkg::FS_MUL1)
        begin
            p1_reg <= prod;
        end
        if (state_reg == awar_pkg::FS_MUL2)
        begin
            p2_reg <= prod;
        end
    end

    a_down_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == awar_pkg::MODE_DOWN |-> rem_reg != '0)
        else $error("downsampler slot remainder reached zero");

    a_up_rem_below_unity: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == awar_pkg::MODE_UP |-> !rem_reg[FB])
        else $error("upsampler remainder not below unity");

    a_push_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_data.first_vld || push_data.rpt_cnt != '0))
        else $error("queued descriptor carries no word");

endmodule

FILE: rtl/core/awar_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awar_queue
// Short FIFO of result descriptors between front and back.
// ----------------------------------------------------------------------------
module awar_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  awar_pkg::entry_t  push_data,
    input  logic              pop,
    output awar_pkg::entry_t  pop_data,
    output awar_pkg::q_stat_t stat
);

    localparam int PTR_W = $clog2(awar_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(awar_pkg::Q_DEPTH + 1);

    awar_pkg::entry_t mem_reg [awar_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign stat.full  = cnt_reg == CNT_W'(awar_pkg::Q_DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("descriptor queue underflow");

endmodule

FILE: rtl/core/awar_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awar_back
// Expands descriptors into output words: the leading word, then repeats.
// ----------------------------------------------------------------------------
module awar_back (
    input  logic              clk,
    input  logic              rst_n,
    input  awar_pkg::entry_t  pop_data,
    input  awar_pkg::q_stat_t q_stat,
    output logic              pop,
    awar_out_if.source        dst
);

    localparam int SW = awar_pkg::SAMPLE_W;
    localparam int CW = awar_pkg::CNT_W;

    logic                 cur_vld_reg;
    logic                 first_pend_reg;
    logic [CW-1:0]        rpt_cnt_reg;
    logic signed [SW-1:0] first_val_reg;
    logic signed [SW-1:0] rpt_val_reg;
    logic                 last_reg;
    logic                 is_final;
    logic                 fire;

    assign is_final = first_pend_reg ? (rpt_cnt_reg == '0) : (rpt_cnt_reg == CW'(1));
    assign fire     = cur_vld_reg && dst.ready;
    assign pop      = !q_stat.empty && (!cur_vld_reg || (fire && is_final));

    assign dst.valid      = cur_vld_reg;
    assign dst.out_sample = first_pend_reg ? first_val_reg : rpt_val_reg;
    assign dst.out_last   = last_reg && is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg    <= 1'b0;
            first_pend_reg <= 1'b0;
            rpt_cnt_reg    <= '0;
        end
        else if (pop)
        begin
            cur_vld_reg    <= 1'b1;
            first_pend_reg <= pop_data.first_vld;
            rpt_cnt_reg    <= pop_data.rpt_cnt;
        end
        else if (fire && is_final)
        begin
            cur_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (first_pend_reg)
            begin
                first_pend_reg <= 1'b0;
            end
            else
            begin
                rpt_cnt_reg <= rpt_cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            first_val_reg <= pop_data.first_val;
            rpt_val_reg   <= pop_data.rpt_val;
            last_reg      <= pop_data.last;
        end
    end

endmodule

FILE: rtl/core/area_weighted_audio_resampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_weighted_audio_resampler_unit
// Box-filter sample rate converter for signed 16-bit audio.
// ----------------------------------------------------------------------------
// The front accepts a sample, makes two passes through its single shared
// multiplier and updates the run state (stalling while the queue is full)
// before it takes the next, and queues a descriptor of the words that sample
// causes; the back sends them at one per cycle while the output is ready, so
// an N-word upsampling sample holds the output while a 2-deep queue lets the
// front go on. A ratio write restarts the run and is accepted at once, so it
// must only be sent while the block is idle. No clearing pass follows reset.
module area_weighted_audio_resampler_unit #(
    parameter int FRACTION_BITS = awar_pkg::DEF_FRACTION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    awar_in_if.sink     src,
    awar_out_if.source  dst,
    awar_cfg_if.sink    cfg
);

    logic              push;
    logic              pop;
    awar_pkg::entry_t  push_data;
    awar_pkg::entry_t  pop_data;
    awar_pkg::q_stat_t q_stat;

    awar_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .q_stat    (q_stat)
    );

    awar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    awar_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .q_stat   (q_stat),
        .pop      (pop),
        .dst      (dst)
    );

endmodule
